// File: src/obb_overlap_test_assert.svh
// Assertion macros used by the checker file.
`ifndef OBB_OVERLAP_TEST_ASSERT_SVH
`define OBB_OVERLAP_TEST_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define OBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define OBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants of the oriented-box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

  localparam int unsigned AxisCount = 15;
  localparam int unsigned PipeDepth = 6;

  localparam logic [2:0] RegCenter  = 3'd0;
  localparam logic [2:0] RegHalf    = 3'd1;
  localparam logic [2:0] RegAxisU   = 3'd2;
  localparam logic [2:0] RegAxisV   = 3'd3;
  localparam logic [2:0] RegAxisW   = 3'd4;

  localparam logic [47:0] CenterRst = 48'd0;
  localparam logic [47:0] HalfRst   = 48'd34360262664;
  localparam logic [47:0] AxisURst  = 48'd70368744177664;
  localparam logic [47:0] AxisVRst  = 48'd1073741824;
  localparam logic [47:0] AxisWRst  = 48'd16384;

  // 3-vector of Q1.14 components
  typedef logic signed [15:0] vec16_t [3];

endpackage

`default_nettype wire

// File: src/obb_overlap_test.sv
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating-axis overlap test of a configured box against streamed boxes.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// command   start_i / busy_o           target_* fields
// result    done_o strobe              overlap_o, result_tag_o
// config    APB psel/penable/pwrite    paddr 6 bits, pwdata 64 bits
//
// One transaction per cycle; done_o rises and the result is taken once the item
// has passed the stage registers listed below.
// Stages: unpack and offset, candidate axes, component products, dot products
// and magnitudes, extent terms, reach sums and compare.
// busy_o is always low; the receiver cannot stall so nothing holds.
// Reset clears valid bits and loads the default own box.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_overlap_test import obb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic signed [15:0] target_cx_i,
  input  wire logic signed [15:0] target_cy_i,
  input  wire logic signed [15:0] target_cz_i,
  input  wire logic [14:0]        target_half_len_i,
  input  wire logic [14:0]        target_half_hgt_i,
  input  wire logic [14:0]        target_half_dep_i,
  input  wire logic [47:0]        target_axis_u_i,
  input  wire logic [47:0]        target_axis_v_i,
  input  wire logic [47:0]        target_axis_w_i,
  input  wire logic [15:0]        target_tag_i,
  output      logic               done_o,
  output      logic               overlap_o,
  output      logic [15:0]        result_tag_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output      logic [63:0]        prdata,
  output      logic               pready
);

  logic [47:0] center_q, half_q, au_q, av_q, aw_q;
  logic        wr;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CenterRst;
      half_q   <= HalfRst;
      au_q     <= AxisURst;
      av_q     <= AxisVRst;
      aw_q     <= AxisWRst;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (paddr[5:3])
        RegCenter: center_q <= pwdata[47:0];
        RegHalf:   half_q   <= pwdata[47:0];
        RegAxisU:  au_q     <= pwdata[47:0];
        RegAxisV:  av_q     <= pwdata[47:0];
        RegAxisW:  aw_q     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      RegCenter: prdata = {16'd0, center_q};
      RegHalf:   prdata = {16'd0, half_q};
      RegAxisU:  prdata = {16'd0, au_q};
      RegAxisV:  prdata = {16'd0, av_q};
      RegAxisW:  prdata = {16'd0, aw_q};
      default:   prdata = 64'd0;
    endcase
  end

  // Stage 1: box axes, half extents, centre offset
  logic                    v1_q;
  logic signed [15:0]      ax1_q [6][3];
  logic [15:0]             h1_q  [6];
  logic signed [16:0]      d1_q  [3];
  logic [15:0]             tag1_q;

  function automatic logic signed [15:0] comp(input logic [47:0] p, input int unsigned k);
    logic signed [15:0] r;
    case (k)
      0:       r = p[47:32];
      1:       r = p[31:16];
      default: r = p[15:0];
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ax1_q[0][k] <= comp(au_q, k);
      ax1_q[1][k] <= comp(av_q, k);
      ax1_q[2][k] <= comp(aw_q, k);
      ax1_q[3][k] <= comp(target_axis_u_i, k);
      ax1_q[4][k] <= comp(target_axis_v_i, k);
      ax1_q[5][k] <= comp(target_axis_w_i, k);
    end
    h1_q[0] <= half_q[47:32];
    h1_q[1] <= half_q[31:16];
    h1_q[2] <= half_q[15:0];
    h1_q[3] <= {1'b0, target_half_len_i};
    h1_q[4] <= {1'b0, target_half_hgt_i};
    h1_q[5] <= {1'b0, target_half_dep_i};
    d1_q[0] <= 17'(target_cx_i) - 17'(signed'(center_q[47:32]));
    d1_q[1] <= 17'(target_cy_i) - 17'(signed'(center_q[31:16]));
    d1_q[2] <= 17'(target_cz_i) - 17'(signed'(center_q[15:0]));
    tag1_q  <= target_tag_i;
  end

  // Stage 2: candidate axes in Q.28 (33 bits signed)
  logic                    v2_q;
  logic signed [32:0]      l2_q  [AxisCount][3];
  logic signed [15:0]      ax2_q [6][3];
  logic [15:0]             h2_q  [6];
  logic signed [16:0]      d2_q  [3];
  logic [15:0]             tag2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        l2_q[i][k] <= 33'(ax1_q[i][k]) <<< 14;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        l2_q[6+i*3+j][0] <= 33'(ax1_q[i][1] * ax1_q[3+j][2]) - 33'(ax1_q[i][2] * ax1_q[3+j][1]);
        l2_q[6+i*3+j][1] <= 33'(ax1_q[i][2] * ax1_q[3+j][0]) - 33'(ax1_q[i][0] * ax1_q[3+j][2]);
        l2_q[6+i*3+j][2] <= 33'(ax1_q[i][0] * ax1_q[3+j][1]) - 33'(ax1_q[i][1] * ax1_q[3+j][0]);
      end
    end
    ax2_q  <= ax1_q;
    h2_q   <= h1_q;
    d2_q   <= d1_q;
    tag2_q <= tag1_q;
  end

  // Stage 3: component products (each <= 49 bits signed)
  logic                    v3_q;
  logic signed [49:0]      pd3_q [AxisCount][3];
  logic signed [49:0]      pa3_q [AxisCount][6][3];
  logic [15:0]             h3_q  [6];
  logic [15:0]             tag3_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < AxisCount; j++) begin
      for (int k = 0; k < 3; k++) begin
        pd3_q[j][k] <= 50'(d2_q[k]) * 50'(l2_q[j][k]);
        for (int i = 0; i < 6; i++) begin
          pa3_q[j][i][k] <= 50'(ax2_q[i][k]) * 50'(l2_q[j][k]);
        end
      end
    end
    h3_q   <= h2_q;
    tag3_q <= tag2_q;
  end

  // Stage 4: dot products, magnitudes
  logic                    v4_q;
  logic [51:0]             dd4_q [AxisCount];
  logic [50:0]             da4_q [AxisCount][6];
  logic [15:0]             h4_q  [6];
  logic [15:0]             tag4_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < AxisCount; j++) begin
      logic signed [51:0] s;
      s = 52'(pd3_q[j][0]) + 52'(pd3_q[j][1]) + 52'(pd3_q[j][2]);
      dd4_q[j] <= s[51] ? 52'(-s) : s;
      for (int i = 0; i < 6; i++) begin
        logic signed [51:0] t;
        t = 52'(pa3_q[j][i][0]) + 52'(pa3_q[j][i][1]) + 52'(pa3_q[j][i][2]);
        da4_q[j][i] <= t[51] ? 51'(-t) : 51'(t);
      end
    end
    h4_q   <= h3_q;
    tag4_q <= tag3_q;
  end

  // Stage 5: extent terms and scaled distance
  logic                    v5_q;
  logic [66:0]             dist5_q [AxisCount];
  logic [66:0]             rt5_q   [AxisCount][6];
  logic [15:0]             tag5_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < AxisCount; j++) begin
      dist5_q[j] <= {1'b0, dd4_q[j], 14'd0};
      for (int i = 0; i < 6; i++) begin
        rt5_q[j][i] <= 67'(h4_q[i]) * 67'(da4_q[j][i]);
      end
    end
    tag5_q <= tag4_q;
  end

  // Stage 6: reach sum and compare; exact wide sum matches saturated verdict
  logic        v6_q;
  logic        ov6_q;
  logic [15:0] tag6_q;
  logic        sep;

  always_comb begin
    sep = 1'b0;
    for (int j = 0; j < AxisCount; j++) begin
      logic [69:0] r;
      r = 70'(rt5_q[j][0]) + 70'(rt5_q[j][1]) + 70'(rt5_q[j][2])
        + 70'(rt5_q[j][3]) + 70'(rt5_q[j][4]) + 70'(rt5_q[j][5]);
      if (70'(dist5_q[j]) > r) sep = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ov6_q  <= ~sep;
    tag6_q <= tag5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign done_o       = v6_q;
  assign overlap_o    = ov6_q;
  assign result_tag_o = tag6_q;

endmodule

`default_nettype wire

// File: src/obb_chk.sv
// ----------------------------------------------------------------------------
// obb_chk
// Port-level checks of the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "obb_overlap_test_assert.svh"

module obb_chk import obb_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [15:0] target_tag_i,
  input wire logic        done_o,
  input wire logic [15:0] result_tag_o,
  input wire logic        pready
);

  `OBB_ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o && pready)
  `OBB_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, $past(start_i, PipeDepth) && $past(rst_ni, PipeDepth), done_o)
  `OBB_ASSERT_IMPL(a_tag_echo, clk_i, rst_ni, done_o && $past(rst_ni, PipeDepth), result_tag_o == $past(target_tag_i, PipeDepth))
  `OBB_ASSERT_IMPL(a_no_early, clk_i, rst_ni, $rose(rst_ni), !done_o)

endmodule

bind obb_overlap_test obb_chk u_obb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .target_tag_i (target_tag_i),
  .done_o       (done_o),
  .result_tag_o (result_tag_o),
  .pready       (pready)
);

`default_nettype wire

// File: verif/obb_overlap_test_test.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_test
// Streams target boxes through the separating-axis overlap test under several
// own-box register settings and checks every verdict and echoed tag against an
// exact integer model of the fifteen-axis test.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_overlap_test_test;
  import obb_pkg::*;

  localparam logic [2:0] RegUnused = 3'd5;   // outside the register list
  localparam int unsigned DrainCycles = PipeDepth + 4;
  localparam int unsigned StallLimit  = 4000;
  localparam longint FaceScale = 16384;

  typedef struct {
    logic signed [15:0] cx, cy, cz;
    logic [14:0] half_len, half_hgt, half_dep;
    logic [47:0] axis_u, axis_v, axis_w;
    logic [15:0] tag;
  } target_t;

  typedef struct {
    logic        overlap;
    logic [15:0] tag;
  } verdict_t;

  class OverlapLedger;
    verdict_t pending[$];
    int       mismatches;

    function void note_target(verdict_t v);
      pending.push_back(v);
    endfunction

    function void check_verdict(logic overlap, logic [15:0] tag);
      verdict_t v;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: overlap=%0b tag=%h", overlap, tag);
        return;
      end
      v = pending.pop_front();
      if (overlap !== v.overlap || tag !== v.tag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tag %h: expected overlap=%0b tag=%h, got overlap=%0b tag=%h",
                   v.tag, v.overlap, v.tag, overlap, tag);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  target_t     cur = '{default: '0};
  logic        done_o, overlap_o;
  logic [15:0] result_tag_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // own-box registers as the block should hold them
  logic [47:0] own_ctr = CenterRst, own_half = HalfRst;
  logic [47:0] own_u = AxisURst, own_v = AxisVRst, own_w = AxisWRst;

  OverlapLedger ledger = new();
  int idle_pct = 0;
  int stall_cnt = 0;

  obb_overlap_test dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .target_cx_i(cur.cx), .target_cy_i(cur.cy), .target_cz_i(cur.cz),
    .target_half_len_i(cur.half_len), .target_half_hgt_i(cur.half_hgt),
    .target_half_dep_i(cur.half_dep),
    .target_axis_u_i(cur.axis_u), .target_axis_v_i(cur.axis_v),
    .target_axis_w_i(cur.axis_w), .target_tag_i(cur.tag),
    .done_o, .overlap_o, .result_tag_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  function automatic longint comp(logic [47:0] p, int k);
    logic signed [15:0] c;
    c = p[47 - 16*k -: 16];
    return longint'(c);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic verdict_t predict_verdict(target_t t);
    longint ax[6][3];
    longint cand[15][3];
    longint d[3];
    longint unsigned h[6];
    longint unsigned dist_scaled, reach, term, sum;
    longint dp;
    logic [47:0] packs[6];
    verdict_t v;
    packs = '{own_u, own_v, own_w, t.axis_u, t.axis_v, t.axis_w};
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 3; k++) ax[i][k] = comp(packs[i], k);
    h[0] = own_half[47:32]; h[1] = own_half[31:16]; h[2] = own_half[15:0];
    h[3] = t.half_len; h[4] = t.half_hgt; h[5] = t.half_dep;
    d[0] = longint'(t.cx) - comp(own_ctr, 0);
    d[1] = longint'(t.cy) - comp(own_ctr, 1);
    d[2] = longint'(t.cz) - comp(own_ctr, 2);
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 3; k++) cand[i][k] = ax[i][k] * FaceScale;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cand[6+3*i+j][0] = ax[i][1]*ax[3+j][2] - ax[i][2]*ax[3+j][1];
        cand[6+3*i+j][1] = ax[i][2]*ax[3+j][0] - ax[i][0]*ax[3+j][2];
        cand[6+3*i+j][2] = ax[i][0]*ax[3+j][1] - ax[i][1]*ax[3+j][0];
      end
    v.overlap = 1'b1;
    for (int n = 0; n < 15; n++) begin
      dp = d[0]*cand[n][0] + d[1]*cand[n][1] + d[2]*cand[n][2];
      dist_scaled = mag(dp) * longint'(FaceScale);
      reach = 0;
      for (int i = 0; i < 6; i++) begin
        dp = ax[i][0]*cand[n][0] + ax[i][1]*cand[n][1] + ax[i][2]*cand[n][2];
        term = h[i] * mag(dp);
        sum = reach + term;
        reach = (sum < reach) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
      end
      if (dist_scaled > reach) v.overlap = 1'b0;
    end
    v.tag = t.tag;
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) ledger.note_target(predict_verdict(cur));
    if (rst_ni && done_o) ledger.check_verdict(overlap_o, result_tag_o);
    if ((start_i && !busy_o) || done_o || !rst_ni) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("obb_overlap_test: mismatch");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [47:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegCenter: own_ctr  = val;
      RegHalf:   own_half = val;
      RegAxisU:  own_u    = val;
      RegAxisV:  own_v    = val;
      RegAxisW:  own_w    = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [47:0] c, logic [47:0] h, logic [47:0] u,
                           logic [47:0] v, logic [47:0] w);
    reg_write(RegCenter, c);
    reg_write(RegHalf, h);
    reg_write(RegAxisU, u);
    reg_write(RegAxisV, v);
    reg_write(RegAxisW, w);
    reg_write(RegUnused, 48'({$urandom(), $urandom()}));
  endtask

  // hold start high across back-to-back items; drop it only for idle gaps
  task automatic send_target(target_t t);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cur <= t;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] unit_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [47:0] rand_axis(logic [47:0] own);
    logic [47:0] a;
    a = '0;
    case ($urandom_range(0, 5))
      0, 1: a[47 - 16*$urandom_range(0, 2) -: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      2, 3: a = {unit_comp(), unit_comp(), unit_comp()};
      4:    a = 48'({$urandom(), $urandom()});
      default: a = own;
    endcase
    return a;
  endfunction

  function automatic target_t rand_target();
    target_t t;
    logic full;
    full = ($urandom_range(0, 9) == 0);
    t.cx = full ? 16'($urandom()) : 16'(comp(own_ctr, 0) + $signed($urandom_range(0, 256)) - 128);
    t.cy = full ? 16'($urandom()) : 16'(comp(own_ctr, 1) + $signed($urandom_range(0, 256)) - 128);
    t.cz = full ? 16'($urandom()) : 16'(comp(own_ctr, 2) + $signed($urandom_range(0, 256)) - 128);
    full = ($urandom_range(0, 9) == 0);
    t.half_len = full ? 15'($urandom()) : 15'($urandom_range(0, 64));
    t.half_hgt = full ? 15'($urandom()) : 15'($urandom_range(0, 64));
    t.half_dep = full ? 15'($urandom()) : 15'($urandom_range(0, 64));
    t.axis_u = rand_axis(own_u);
    t.axis_v = rand_axis(own_v);
    t.axis_w = rand_axis(own_w);
    t.tag = 16'($urandom());
    return t;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_target(rand_target());
  endtask

  initial begin
    target_t t;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items against the default unit box
    idle_pct = 20;
    t = '{cx: 16'sd16, cy: 0, cz: 0, half_len: 15'd8, half_hgt: 15'd8, half_dep: 15'd8,
          axis_u: AxisURst, axis_v: AxisVRst, axis_w: AxisWRst, tag: 16'h0000};
    send_target(t);                                   // touching faces
    t.cx = 16'sd17; t.tag = 16'hFFFF; send_target(t);  // just apart
    t.cx = 0; t.tag = 16'h0001; send_target(t);        // parallel axes, coincident
    t.half_len = 0; t.half_hgt = 0; t.half_dep = 0; t.tag = 16'h0002;
    send_target(t);                                   // point box
    t.cx = 16'sh7FFF; t.cy = 16'sh7FFF; t.cz = 16'sh7FFF; t.tag = 16'h0003;
    send_target(t);
    t.half_len = 15'h7FFF; t.half_hgt = 15'h7FFF; t.half_dep = 15'h7FFF; t.tag = 16'h0004;
    send_target(t);
    t.cx = 16'sh8000; t.cy = 16'sh8000; t.cz = 16'sh8000; t.tag = 16'h0005;
    send_target(t);
    t.half_len = 15'd1; t.tag = 16'h0006; send_target(t);
    t.axis_u = 48'hFFFF_FFFF_FFFF; t.axis_v = 48'h8000_8000_8000;
    t.axis_w = 48'h7FFF_7FFF_7FFF; t.tag = 16'h0007; send_target(t);
    t.cx = 0; t.cy = 0; t.cz = 0; t.axis_u = 0; t.axis_v = 0; t.axis_w = 0;
    t.tag = 16'h0008; send_target(t);                  // all target axes zero
    t.axis_u = 48'h2D41_2D41_0000; t.axis_v = 48'hD2BF_2D41_0000; t.axis_w = AxisWRst;
    t.cx = 16'sd22; t.cy = 16'sd2; t.half_len = 15'd8; t.half_hgt = 15'd8;
    t.half_dep = 15'd8; t.tag = 16'h0009; send_target(t);  // rotated about z
    t.cx = 16'sd40; t.tag = 16'h000A; send_target(t);
    drain();

    idle_pct = 35;
    configure({16'($urandom()), 16'($urandom()), 16'($urandom())},
              {16'($urandom_range(0, 80)), 16'($urandom_range(0, 80)),
               16'($urandom_range(0, 80))},
              48'h2D41_2D41_0000, 48'hD2BF_2D41_0000, AxisWRst);
    run_random(130);
    drain();

    // extreme register values
    idle_pct = 65;
    configure(48'h8000_7FFF_8000, 48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000,
              48'h7FFF_7FFF_7FFF, 48'hFFFF_0000_FFFF);
    run_random(60);
    drain();
    configure(48'h0, 48'h0, AxisURst, AxisVRst, AxisWRst);
    run_random(60);
    drain();

    idle_pct = 0;
    configure({16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 16'd0},
              {16'($urandom()), 16'($urandom()), 16'($urandom())},
              {unit_comp(), unit_comp(), unit_comp()},
              {unit_comp(), unit_comp(), unit_comp()},
              {unit_comp(), unit_comp(), unit_comp()});
    run_random(70);
    drain();
    configure(48'h0, 48'h0000_0010_0010, AxisURst, AxisVRst, AxisWRst);
    run_random(70);
    drain();

    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("obb_overlap_test: match");
    end else begin
      $display("obb_overlap_test: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
